/* rtl/core/scs_pkg.sv */
// ============================================================================
// scs_pkg
// Shared types and codes for the sparse column entry store.
// ============================================================================
package scs_pkg;

    // request modes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        row_index;
        logic [7:0]         column_index;
        logic signed [31:0] entry_value;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic [10:0]        position;
        logic [1:0]         status;
        logic [10:0]        entry_count;
    } rsp_word_t;

endpackage

/* rtl/core/scs_ptr_mem.sv */
// ============================================================================
// scs_ptr_mem
// Column start pointer memory: one synchronous read and one write port,
// read data registered. After reset a clearing pass writes zero to every
// entry, one per cycle; clr_busy is high until the pass ends.
// ============================================================================
module scs_ptr_mem #(
    parameter int DEPTH = 257,
    parameter int AW    = 9,
    parameter int DW    = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic          clr_busy
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    // storage array, cleared entry by entry after reset
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // clearing pass sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;
endmodule

/* rtl/core/scs_entry_mem.sv */
// ============================================================================
// scs_entry_mem
// Entry memory: row index and value per slot, one read and one write port,
// read data registered. Contents undefined until written.
// ============================================================================
module scs_entry_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

/* rtl/core/sparse_column_entry_store.sv */
// ============================================================================
// sparse_column_entry_store
// Sparse matrix in compressed column form with lookup, set and remove.
// ============================================================================
//  channel | direction | handshake        | word
//  req     | in        | req_valid/ready  | req_word_t
//  rsp     | out       | rsp_valid/ready  | rsp_word_t
//  cfg     | in        | cfg_we           | cfg_index, cfg_data
//
// One request at a time. After the accepting edge: range check and the two
// pointer reads (out of range ends in the first), then up to floor(log2 of
// column size) + 1 search steps, then a check of the final slot. Insert or
// remove then shifts the slots above the position and rewrites each pointer
// above the column. Reset clears all MAX_COLUMNS + 1 pointers before the
// first request; the next request is taken once the result word is gone.
module sparse_column_entry_store #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_COLUMNS = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  scs_pkg::req_word_t    req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output scs_pkg::rsp_word_t    rsp,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_data
);
    import scs_pkg::*;

    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int PAW = $clog2(MAX_COLUMNS + 1);
    localparam int EDW = 16 + VALUE_WIDTH;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_PLO    = 12'b000000000010,
        S_PHI    = 12'b000000000100,
        S_PWAIT  = 12'b000000001000,
        S_SRCH   = 12'b000000010000,
        S_SRD    = 12'b000000100000,
        S_CHK    = 12'b000001000000,
        S_CHKRD  = 12'b000010000000,
        S_SHRD   = 12'b000100000000,
        S_SHWR   = 12'b001000000000,
        S_CPRD   = 12'b010000000000,
        S_CPWR   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    req_word_t req_reg;
    logic [16:0] row_count_reg;
    logic [8:0]  column_count_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] hi_lim_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] slot_reg, slot_next;
    logic [PAW:0]  col_reg, col_next;
    logic rsp_valid_reg;
    rsp_word_t rsp_reg;
    // saved old value for the deferred result of insert/remove
    logic signed [31:0] keep_val_reg;

    // memory ports
    logic [PAW-1:0] p_raddr, p_waddr;
    logic [CW-1:0]  p_rdata, p_wdata;
    logic           p_we;
    logic           p_busy;
    logic [EAW-1:0] e_raddr, e_waddr;
    logic [EDW-1:0] e_rdata, e_wdata;
    logic           e_we;

    scs_ptr_mem #(.DEPTH(MAX_COLUMNS + 1), .AW(PAW), .DW(CW)) u_ptr (
        .clk(clk), .rst_n(rst_n), .rd_addr(p_raddr), .rd_data(p_rdata),
        .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
        .clr_busy(p_busy)
    );

    scs_entry_mem #(.DEPTH(MAX_ENTRIES), .AW(EAW), .DW(EDW)) u_ent (
        .clk(clk), .rd_addr(e_raddr), .rd_data(e_rdata),
        .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata)
    );

    // decoded request fields
    logic [CW-1:0] mid;
    logic [15:0]   e_row;
    logic [VALUE_WIDTH-1:0] e_val;
    logic [VALUE_WIDTH-1:0] new_val;
    logic [8:0]  cols_lim;
    logic        in_range;
    logic        hit;
    logic signed [31:0] old_val;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign e_row   = e_rdata[EDW-1:VALUE_WIDTH];
    assign e_val   = e_rdata[VALUE_WIDTH-1:0];
    assign new_val = VALUE_WIDTH'(req_reg.entry_value);
    assign cols_lim = (32'(column_count_reg) < MAX_COLUMNS) ? column_count_reg
                                                             : 9'(MAX_COLUMNS);
    assign in_range = ({1'b0, req_reg.row_index} < row_count_reg) &&
                      ({1'b0, req_reg.column_index} < cols_lim);
    assign hit      = (pos_reg < hi_lim_reg) && (e_row == req_reg.row_index);
    assign old_val  = 32'(signed'(e_val));

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg && !p_busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 17'd65536;
            column_count_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // sequencer: next state and memory control
    logic          fin;
    rsp_word_t     fin_word;
    logic [CW-1:0] cnt_next;
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        slot_next  = slot_reg;
        col_next   = col_reg;
        cnt_next   = count_reg;
        p_raddr    = PAW'(req_reg.column_index);
        p_we       = 1'b0;
        p_waddr    = col_reg[PAW-1:0];
        p_wdata    = '0;
        e_raddr    = mid[EAW-1:0];
        e_we       = 1'b0;
        e_waddr    = slot_reg[EAW-1:0];
        e_wdata    = e_rdata;
        fin        = 1'b0;
        fin_word   = '0;
        fin_word.entry_count = 11'(count_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                    state_next = S_PLO;
            end
            S_PLO:
            begin
                if (!in_range)
                begin
                    fin             = 1'b1;
                    fin_word.status = ST_RANGE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    p_raddr    = PAW'(req_reg.column_index);
                    state_next = S_PHI;
                end
            end
            S_PHI:
            begin
                p_raddr    = PAW'({1'b0, req_reg.column_index} + 9'd1);
                lo_next    = p_rdata;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                hi_next = (p_rdata > count_reg) ? count_reg : p_rdata;
                if (lo_reg > hi_next)
                    lo_next = hi_next;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                // one binary search step: read the middle slot, or the final slot once the window is empty
                if (lo_reg < hi_reg)
                begin
                    e_raddr    = mid[EAW-1:0];
                    state_next = S_SRD;
                end
                else
                begin
                    e_raddr    = lo_reg[EAW-1:0];
                    state_next = S_CHK;
                end
            end
            S_SRD:
            begin
                if (e_row < req_reg.row_index)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = S_SRCH;
            end
            S_CHK:
            begin
                // pos_reg holds final slot; read data pending
                state_next = S_CHKRD;
            end
            S_CHKRD:
            begin
                fin_word.position = 11'(pos_reg);
                if (hit)
                begin
                    fin_word.found      = 1'b1;
                    fin_word.read_value = old_val;
                end
                fin = 1'b1;
                state_next = S_IDLE;
                if (req_reg.mode == MODE_SET)
                begin
                    if (hit)
                    begin
                        e_we    = 1'b1;
                        e_waddr = pos_reg[EAW-1:0];
                        e_wdata = {req_reg.row_index, new_val};
                    end
                    else if (32'(count_reg) >= MAX_ENTRIES)
                        fin_word.status = ST_FULL;
                    else
                    begin
                        fin        = 1'b0;
                        slot_next  = count_reg;
                        state_next = S_SHRD;
                    end
                end
                else if (req_reg.mode == MODE_REMOVE && hit)
                begin
                    fin        = 1'b0;
                    slot_next  = pos_reg + 1'b1;
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (req_reg.mode == MODE_SET)
                begin
                    if (slot_reg > pos_reg)
                    begin
                        e_raddr    = EAW'(slot_reg - 1'b1);
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        e_we       = 1'b1;
                        e_waddr    = pos_reg[EAW-1:0];
                        e_wdata    = {req_reg.row_index, new_val};
                        col_next   = (PAW+1)'(req_reg.column_index) + 1'b1;
                        state_next = S_CPRD;
                    end
                end
                else
                begin
                    if (slot_reg < count_reg)
                    begin
                        e_raddr    = slot_reg[EAW-1:0];
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        col_next   = (PAW+1)'(req_reg.column_index) + 1'b1;
                        state_next = S_CPRD;
                    end
                end
            end
            S_SHWR:
            begin
                e_we = 1'b1;
                e_wdata = e_rdata;
                if (req_reg.mode == MODE_SET)
                begin
                    e_waddr   = slot_reg[EAW-1:0];
                    slot_next = slot_reg - 1'b1;
                end
                else
                begin
                    e_waddr   = EAW'(slot_reg - 1'b1);
                    slot_next = slot_reg + 1'b1;
                end
                state_next = S_SHRD;
            end
            S_CPRD:
            begin
                // walk following column pointers
                if (32'(col_reg) <= MAX_COLUMNS)
                begin
                    p_raddr    = col_reg[PAW-1:0];
                    state_next = S_CPWR;
                end
                else
                begin
                    cnt_next = (req_reg.mode == MODE_SET) ? count_reg + 1'b1
                                                          : count_reg - 1'b1;
                    fin                  = 1'b1;
                    fin_word.position    = 11'(pos_reg);
                    fin_word.found       = (req_reg.mode == MODE_REMOVE);
                    fin_word.read_value  = keep_val_reg;
                    fin_word.entry_count = 11'(cnt_next);
                    state_next = S_IDLE;
                end
            end
            S_CPWR:
            begin
                p_we = 1'b1;
                if (req_reg.mode == MODE_SET)
                    p_wdata = p_rdata + 1'b1;
                else
                    p_wdata = (p_rdata != '0) ? p_rdata - 1'b1 : p_rdata;
                col_next   = col_reg + 1'b1;
                state_next = S_CPRD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= cnt_next;
            if (fin)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // request, search window and result word
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        slot_reg <= slot_next;
        col_reg  <= col_next;
        if (state_reg == S_PWAIT)
            hi_lim_reg <= hi_next;
        if (state_reg == S_SRCH)
            pos_reg <= lo_reg;
        if (state_reg == S_CHKRD)
            keep_val_reg <= hit ? old_val : 32'sd0;
        if (fin)
            rsp_reg <= fin_word;
    end
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse column entry store testbench
// Drives lookup, set and remove requests with random bursts and response
// stalls. A behavioral copy of the compressed column store predicts every
// response word, which the monitor checks field by field.
// ----------------------------------------------------------------------------
module testbench;
    import scs_pkg::*;

    localparam int ENTRIES = 1024;
    localparam int COLUMNS = 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_word_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_word_t rsp;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [16:0] cfg_data = '0;

    sparse_column_entry_store u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // shadow store
    logic [16:0] shadow_rows_limit;
    logic [8:0]  shadow_cols_limit;
    logic [10:0] shadow_starts [0:COLUMNS];
    logic [15:0] shadow_rows [0:ENTRIES-1];
    logic [31:0] shadow_vals [0:ENTRIES-1];
    int          shadow_count;

    req_word_t pending_words [$];
    rsp_word_t expected_rsps [$];
    int  error_count = 0;
    bit  hold_off = 1'b0;

    function automatic rsp_word_t apply_request(req_word_t w);
        rsp_word_t r;
        int lo;
        int hi;
        int hi_lim;
        int mid;
        int lim;
        r = '0;
        lim = (int'(shadow_cols_limit) < COLUMNS) ? int'(shadow_cols_limit) : COLUMNS;
        if (w.row_index >= shadow_rows_limit || w.column_index >= lim) begin
            r.status = ST_RANGE;
        end
        else begin
            lo = int'(shadow_starts[w.column_index]);
            hi = int'(shadow_starts[w.column_index + 1]);
            if (hi > shadow_count) hi = shadow_count;
            if (lo > hi) lo = hi;
            hi_lim = hi;
            // lower bound search within the column
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (shadow_rows[mid] < w.row_index) lo = mid + 1;
                else hi = mid;
            end
            r.position = lo[10:0];
            if (lo < hi_lim && shadow_rows[lo] == w.row_index) begin
                r.found = 1'b1;
                r.read_value = shadow_vals[lo];
            end
            if (w.mode == MODE_SET) begin
                if (r.found) shadow_vals[lo] = w.entry_value;
                else if (shadow_count >= ENTRIES) r.status = ST_FULL;
                else begin
                    for (int s = shadow_count; s > lo; s--) begin
                        shadow_rows[s] = shadow_rows[s-1];
                        shadow_vals[s] = shadow_vals[s-1];
                    end
                    shadow_rows[lo] = w.row_index;
                    shadow_vals[lo] = w.entry_value;
                    for (int c = w.column_index + 1; c <= COLUMNS; c++)
                        shadow_starts[c] = shadow_starts[c] + 11'd1;
                    shadow_count++;
                end
            end
            else if (w.mode == MODE_REMOVE && r.found) begin
                for (int s = lo + 1; s < shadow_count; s++) begin
                    shadow_rows[s-1] = shadow_rows[s];
                    shadow_vals[s-1] = shadow_vals[s];
                end
                for (int c = w.column_index + 1; c <= COLUMNS; c++)
                    if (shadow_starts[c] > 0) shadow_starts[c] = shadow_starts[c] - 11'd1;
                shadow_count--;
            end
        end
        r.entry_count = shadow_count[10:0];
        return r;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && req_ready) begin
                expected_rsps.push_back(apply_request(req));
                void'(pending_words.pop_front());
            end
            if (req_valid && !req_ready) begin
                // hold the word
            end
            else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !(req_valid && req_ready &&
                     pending_words.size() == 0)) begin
                if (req_valid && req_ready && pending_words.size() == 0)
                    req_valid <= 1'b0;
                else begin
                    req_valid <= 1'b1;
                    req <= pending_words[0];
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 12);
                        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 15);
                    end
                    else burst_left <= burst_left - 1;
                end
            end
            else req_valid <= 1'b0;
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    int hold_cycles = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response word");
                    error_count++;
                end
                else begin
                    rsp_word_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.found !== e.found) begin
                        $error("found exp %0d got %0d", e.found, rsp.found);
                        error_count++;
                    end
                    if (rsp.read_value !== e.read_value) begin
                        $error("read_value exp %0d got %0d", e.read_value, rsp.read_value);
                        error_count++;
                    end
                    if (rsp.position !== e.position) begin
                        $error("position exp %0d got %0d", e.position, rsp.position);
                        error_count++;
                    end
                    if (rsp.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.entry_count !== e.entry_count) begin
                        $error("entry_count exp %0d got %0d", e.entry_count, rsp.entry_count);
                        error_count++;
                    end
                end
            end
            if (hold_off && hold_cycles < 3000) begin
                hold_cycles <= hold_cycles + 1;
                rsp_ready <= 1'b0;
            end
            else begin
                stall_phase <= (stall_phase + 1) % 64;
                rsp_ready <= (stall_phase < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic req_word_t make_word(logic [1:0] m, int row, int col, int val);
        req_word_t w;
        w.mode = m;
        w.row_index = row[15:0];
        w.column_index = col[7:0];
        w.entry_value = val;
        return w;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_ROW_COUNT) shadow_rows_limit = data;
        else shadow_cols_limit = data[8:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random phase: mostly small hot set, some noise
    task automatic random_items(int n, int rows, int cols);
        int m;
        for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 9);
            if (m == 0)
                pending_words.push_back(make_word(2'($urandom_range(0, 3)), $urandom,
                    $urandom, $urandom));
            else
                pending_words.push_back(make_word(
                    (m < 5) ? MODE_SET : (m < 8) ? MODE_LOOKUP : MODE_REMOVE,
                    $urandom_range(0, rows - 1), $urandom_range(0, cols - 1), $urandom));
        end
    endtask

    initial begin
        shadow_rows_limit = 17'd65536;
        shadow_cols_limit = 9'd256;
        shadow_count = 0;
        for (int c = 0; c <= COLUMNS; c++) shadow_starts[c] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every mode, absent remove, mode 3
        pending_words.push_back(make_word(MODE_LOOKUP, 0, 0, 0));
        pending_words.push_back(make_word(MODE_REMOVE, 5, 3, 0));
        pending_words.push_back(make_word(MODE_SET, 0, 0, 32'h7fffffff));
        pending_words.push_back(make_word(MODE_SET, 65535, 255, 32'h80000000));
        pending_words.push_back(make_word(MODE_SET, 100, 0, -1));
        pending_words.push_back(make_word(MODE_SET, 50, 0, 7));
        pending_words.push_back(make_word(MODE_SET, 100, 0, 12));
        pending_words.push_back(make_word(2'd3, 100, 0, 0));
        pending_words.push_back(make_word(MODE_LOOKUP, 65535, 255, 0));
        pending_words.push_back(make_word(MODE_SET, 1, 128, 32'h55aa55aa));
        pending_words.push_back(make_word(MODE_REMOVE, 50, 0, 0));
        pending_words.push_back(make_word(MODE_LOOKUP, 100, 0, 0));
        pending_words.push_back(make_word(MODE_REMOVE, 65535, 255, 0));
        wait_idle();

        // out of range at the small extremes
        write_reg(REG_ROW_COUNT, 17'd1);
        write_reg(REG_COLUMN_COUNT, 17'd1);
        pending_words.push_back(make_word(MODE_SET, 1, 0, 3));
        pending_words.push_back(make_word(MODE_SET, 0, 1, 3));
        pending_words.push_back(make_word(MODE_SET, 0, 0, 3));
        pending_words.push_back(make_word(MODE_LOOKUP, 0, 0, 0));
        wait_idle();

        // mid settings with a long receiver hold-off
        write_reg(REG_ROW_COUNT, 17'd40);
        write_reg(REG_COLUMN_COUNT, 17'd8);
        hold_off = 1'b1;
        random_items(60, 48, 10);
        wait_idle();

        // fill the store to see the full case
        write_reg(REG_ROW_COUNT, 17'd65536);
        write_reg(REG_COLUMN_COUNT, 17'd256);
        for (int i = 0; i < 1030; i++) begin
            int col;
            col = (i * 37) % 4;
            pending_words.push_back(make_word(MODE_SET, $urandom_range(0, 65535),
                col, $urandom));
        end
        random_items(30, 65536, 4);
        wait_idle();

        // drain with removes at random, column count beyond the store
        write_reg(REG_COLUMN_COUNT, 17'd300);
        random_items(40, 65536, 256);
        wait_idle();

        if (error_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end
endmodule
